// ----- sv/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg: shared definitions for the wildcard glob matcher
// Item mode codes, wildcard characters and default sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  // Default pattern store depth
  localparam int PATTERN_MAX_DEF = 64;

  // Wildcard bytes
  localparam logic [7:0] STAR_CHAR = 8'd42;
  localparam logic [7:0] ANY_CHAR  = 8'd63;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_EOT    = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ----- sv/wgm_step.sv -----
// ----------------------------------------------------------------------------
// wgm_step: one text byte step of the position automaton
// Advances the active position set over one byte and closes it over star runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wgm_step
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int LW = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [7:0]           pat       [PATTERN_MAX],
  input  wire logic [LW-1:0]        pat_len,
  input  wire logic [PATTERN_MAX:0] act,
  input  wire logic [7:0]           char_value,
  output logic      [PATTERN_MAX:0] act_next
);

  logic [PATTERN_MAX:0] star_m;   // star positions inside the pattern
  logic [PATTERN_MAX:0] raw;      // set after the byte, before closure
  logic [PATTERN_MAX:0] gen;      // active stars that start propagation
  logic [PATTERN_MAX:0] sum;      // top bit of star_m is never set, so no carry out
  logic [PATTERN_MAX:0] carry;

  // Per-position match, independent lanes
  always_comb begin
    star_m = '0;
    raw    = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < pat_len) begin
        if (pat[i] == STAR_CHAR) begin
          star_m[i] = 1'b1;
          if (act[i]) raw[i] = 1'b1;
        end else if (act[i] && (pat[i] == ANY_CHAR || pat[i] == char_value)) begin
          raw[i+1] = 1'b1;
        end
      end
    end
  end

  // Closure over star runs: carries of star_m + gen mark reached positions
  assign gen      = raw & star_m;
  assign sum      = star_m + gen;
  assign carry    = sum ^ star_m ^ gen;
  assign act_next = raw | carry;

endmodule

`default_nettype wire

// ----- sv/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: whole-text glob match with '*' and '?'
// Bit-parallel position automaton over a loaded pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_mode, in_char_value) carries one
//   transaction per item: clear pattern, append pattern byte, text byte or
//   end of text. Only end of text produces a result transaction on the
//   output channel (out_valid/out_ready, out_matched, out_overflow).
//   An end-of-text item sits in the input register once accepted, then
//   loads the result register. One item is accepted per cycle while
//   in_ready is high; the byte step and star closure for all positions
//   are combinational, through the one wide carry chain of the closure.
//   When the receiver stalls, the result register holds and the input
//   register still takes items; only an end-of-text item waits behind a
//   full result register, and then in_ready drops.
//   Reset empties the pattern, clears the overflow flag and starts a fresh
//   text. Pattern bytes beyond PATTERN_MAX are dropped and flag overflow,
//   which forces no match until the next clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_char_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_overflow
);

  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int SAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Input register
  logic       ivld_r;
  mode_t      mode_r;
  logic [7:0] char_r;

  // Pattern and text state
  logic [7:0]           pat_r [PATTERN_MAX];
  logic [LW-1:0]        len_r, len_nxt;
  logic [PATTERN_MAX:0] start_r, start_nxt;   // closure of {0} for this pattern
  logic [PATTERN_MAX:0] act_r, act_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 ovf_r, ovf_nxt;

  // Result register
  logic out_valid_r, out_matched_r, out_overflow_r;

  logic                 adv;
  logic                 room;
  logic [PATTERN_MAX:0] act_base;
  logic [PATTERN_MAX:0] act_step;

  // Pipeline control: only end of text needs a free result register
  assign adv      = ivld_r && (mode_r != MODE_EOT || !out_valid_r || out_ready);
  assign in_ready = !ivld_r || adv;
  assign room     = (len_r < LW'(PATTERN_MAX));
  assign act_base = fresh_r ? start_r : act_r;

  wgm_step #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_step (
    .pat        (pat_r),
    .pat_len    (len_r),
    .act        (act_base),
    .char_value (char_r),
    .act_next   (act_step)
  );

  // Next state per mode
  always_comb begin
    len_nxt   = len_r;
    start_nxt = start_r;
    act_nxt   = act_r;
    fresh_nxt = fresh_r;
    ovf_nxt   = ovf_r;
    if (adv) begin
      case (mode_r)
        MODE_CLEAR: begin
          len_nxt   = '0;
          start_nxt = {{PATTERN_MAX{1'b0}}, 1'b1};
          act_nxt   = '0;
          fresh_nxt = 1'b1;
          ovf_nxt   = 1'b0;
        end
        MODE_APPEND: begin
          if (room) begin
            len_nxt = len_r + LW'(1);
            if (start_r[len_r] && char_r == STAR_CHAR) start_nxt[len_r + LW'(1)] = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          fresh_nxt = 1'b1;
        end
        MODE_TEXT: begin
          act_nxt   = act_step;
          fresh_nxt = 1'b0;
        end
        MODE_EOT: begin
          fresh_nxt = 1'b1;
        end
        default: begin
          fresh_nxt = fresh_r;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ivld_r <= 1'b1;
    end else if (adv) begin
      ivld_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      mode_r <= mode_t'(in_mode);
      char_r <= in_char_value;
    end
  end

  // Pattern store, written at the fill point
  always_ff @(posedge clk) begin
    if (adv && mode_r == MODE_APPEND && room) begin
      pat_r[len_r[SAW-1:0]] <= char_r;
    end
  end

  // Automaton state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      start_r <= {{PATTERN_MAX{1'b0}}, 1'b1};
      act_r   <= '0;
      fresh_r <= 1'b1;
      ovf_r   <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      start_r <= start_nxt;
      act_r   <= act_nxt;
      fresh_r <= fresh_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && mode_r == MODE_EOT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && mode_r == MODE_EOT) begin
      out_matched_r  <= act_base[len_r] && !ovf_r;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

endmodule

`default_nettype wire
